// File: rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise-linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

	localparam int MAX_POINTS_DEF = 128;

	// request kinds
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_BELOW = 2'd1;
	localparam logic [1:0] STATUS_NO_ABOVE = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic append;      // store vertex from request
		logic load_query;  // latch query x, reset scan
		logic scan;        // walk vertex memory
		logic prep;        // form span, offset, |dy|
		logic mul;         // |dy| * offset
		logic div;         // one divider step
		logic load_out;    // capture result into output register
	} pli_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic need_div;
		logic div_done;
		logic out_free;
	} pli_sts_t;

endpackage

`default_nettype wire

// File: rtl/pli_if.sv
// ----------------------------------------------------------------------------
// pli_req_if / pli_rsp_if
// Valid/ready channels for interpolator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic               first_vertex;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;

	modport source (output valid, req_type, first_vertex, coord_x, coord_y, input ready);
	modport sink   (input valid, req_type, first_vertex, coord_x, coord_y, output ready);
endinterface

interface pli_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] interp_y;
	logic [1:0]         status;

	modport source (output valid, interp_y, status, input ready);
	modport sink   (input valid, interp_y, status, output ready);
endinterface

`default_nettype wire

// File: rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Polyline vertex table with linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// An append request (req_type 0) stores one vertex; with first_vertex set it
// restarts the table, and appends to a full table are dropped. A query
// request (req_type 1) walks the N stored vertices out of a single-port
// memory, one per cycle, tracking the nearest x below and above the query x.
// If both neighbors exist and no vertex hits the query x exactly, a 32x32
// multiply and a 32-step restoring divide follow. The request side is busy
// for the whole query. Each result sits in an output register until taken;
// a query that finishes while an earlier result is still pending waits for
// it. No result is produced for appends.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pli_req_if.sink  req,
	pli_rsp_if.source rsp
);

	// controller <-> datapath handshake
	pli_pkg::pli_cmd_t cmd;
	pli_pkg::pli_sts_t sts;

	// sequencer: owns the request-side ready
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// storage, scan, arithmetic and the result register
	pli_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.first_vertex (req.first_vertex),
		.coord_x      (req.coord_x),
		.coord_y      (req.coord_y),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.interp_y     (rsp.interp_y),
		.status       (rsp.status)
	);

endmodule

`default_nettype wire

// File: rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer: accept, scan, prep, multiply, divide, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_type,
	output logic                   req_ready,
	output pli_pkg::pli_cmd_t      cmd,
	input  wire pli_pkg::pli_sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == pli_pkg::REQ_QUERY) begin
						cmd.load_query = 1'b1;
						state_nxt      = ST_SCAN;
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = sts.need_div ? ST_PREP : ST_FIN;
				end
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pli_dp.sv
// ----------------------------------------------------------------------------
// pli_dp
// Vertex memory, neighbor scan, multiplier, restoring divider, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_dp #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pli_pkg::pli_cmd_t  cmd,
	output pli_pkg::pli_sts_t       sts,
	input  wire logic               first_vertex,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic signed [31:0]      interp_y,
	output logic [1:0]              status
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
	localparam logic [pli_pkg::DIV_CNT_W-1:0] DIV_LAST =
		pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1);

	// vertex storage
	logic [31:0] mem_x [MAX_POINTS];
	logic [31:0] mem_y [MAX_POINTS];

	logic [CW-1:0] count_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;

	// scan
	logic [CW-1:0]      rd_idx_q;
	logic               rd_en;
	logic               rd_vld_s1;
	logic signed [31:0] rd_x_s1;
	logic signed [31:0] rd_y_s1;
	logic signed [31:0] qx_q;

	logic               hit_q, have_lo_q, have_hi_q;
	logic signed [31:0] hit_y_q, lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic               upd_hit, upd_lo, upd_hi;

	// interpolation
	logic [32:0] dy_up, dy_dn;
	logic [31:0] mag_q, off_q, span_q;
	logic        neg_q;
	logic [63:0] prod;
	logic [31:0] rem_q, quo_q;
	logic [33:0] trial;
	logic        ge;
	logic [pli_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// result
	logic [33:0]        lo_ext, q_ext, sum_add, sum_sub, sum;
	logic signed [31:0] sat_y;
	logic signed [31:0] res_y;
	logic [1:0]         res_status;
	logic               rsp_valid_q;
	logic signed [31:0] out_y_q;
	logic [1:0]         out_status_q;

	// ---------------- append ----------------
	assign wr_en   = cmd.append && (first_vertex || (count_q != CNT_MAX));
	assign wr_addr = first_vertex ? '0 : count_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append) begin
			if (first_vertex) begin
				count_q <= CW'(1);
			end else if (count_q != CNT_MAX) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// ---------------- memory ----------------
	assign rd_en = cmd.scan && (rd_idx_q != count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= coord_x;
			mem_y[wr_addr] <= coord_y;
		end
		if (rd_en) begin
			rd_x_s1 <= mem_x[rd_idx_q[AW-1:0]];
			rd_y_s1 <= mem_y[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.load_query) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	// ---------------- neighbor tracking ----------------
	// strict compares keep the earliest vertex on ties
	assign upd_hit = rd_vld_s1 && (rd_x_s1 == qx_q) && !hit_q;
	assign upd_lo  = rd_vld_s1 && (rd_x_s1 < qx_q) && (!have_lo_q || (rd_x_s1 > lo_x_q));
	assign upd_hi  = rd_vld_s1 && (rd_x_s1 > qx_q) && (!have_hi_q || (rd_x_s1 < hi_x_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
		end else if (cmd.load_query) begin
			hit_q     <= 1'b0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
		end else begin
			if (upd_hit) hit_q <= 1'b1;
			if (upd_lo) have_lo_q <= 1'b1;
			if (upd_hi) have_hi_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q <= coord_x;
		end
		if (upd_hit) hit_y_q <= rd_y_s1;
		if (upd_lo) begin
			lo_x_q <= rd_x_s1;
			lo_y_q <= rd_y_s1;
		end
		if (upd_hi) begin
			hi_x_q <= rd_x_s1;
			hi_y_q <= rd_y_s1;
		end
	end

	// ---------------- prep / multiply / divide ----------------
	assign dy_up = {hi_y_q[31], hi_y_q} - {lo_y_q[31], lo_y_q};
	assign dy_dn = {lo_y_q[31], lo_y_q} - {hi_y_q[31], hi_y_q};
	assign prod  = 64'(mag_q) * 64'(off_q);

	// remainder stays below span, so {rem, next bit} < 2*span
	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, span_q};
	assign ge    = !trial[33];

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q  <= dy_up[32];
			mag_q  <= dy_up[32] ? dy_dn[31:0] : dy_up[31:0];
			off_q  <= qx_q - lo_x_q;
			span_q <= hi_x_q - lo_x_q;
		end
		if (cmd.mul) begin
			rem_q <= prod[63:32];
			quo_q <= prod[31:0];
		end else if (cmd.div) begin
			rem_q <= ge ? trial[31:0] : {rem_q[30:0], quo_q[31]};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.mul) begin
			div_cnt_q <= '0;
		end else if (cmd.div) begin
			div_cnt_q <= div_cnt_q + pli_pkg::DIV_CNT_W'(1);
		end
	end

	// ---------------- result ----------------
	assign lo_ext  = {{2{lo_y_q[31]}}, lo_y_q};
	assign q_ext   = {2'b00, quo_q};
	assign sum_add = lo_ext + q_ext;
	assign sum_sub = lo_ext - q_ext;
	assign sum     = neg_q ? sum_sub : sum_add;

	always_comb begin
		if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
			sat_y = sum[31:0];
		end else if (sum[33]) begin
			sat_y = 32'sh8000_0000;
		end else begin
			sat_y = 32'sh7fff_ffff;
		end
	end

	always_comb begin
		res_y      = '0;
		res_status = pli_pkg::STATUS_OK;
		if (count_q == '0) begin
			res_status = pli_pkg::STATUS_EMPTY;
		end else if (hit_q) begin
			res_y = hit_y_q;
		end else if (!have_lo_q) begin
			res_status = pli_pkg::STATUS_NO_BELOW;
		end else if (!have_hi_q) begin
			res_status = pli_pkg::STATUS_NO_ABOVE;
		end else begin
			res_y = sat_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_y_q      <= res_y;
			out_status_q <= res_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign interp_y  = out_y_q;
	assign status    = out_status_q;

	assign sts.scan_done = (rd_idx_q == count_q) && !rd_vld_s1;
	assign sts.need_div  = have_lo_q && have_hi_q && !hit_q;
	assign sts.div_done  = (div_cnt_q == DIV_LAST);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

endmodule

`default_nettype wire

// File: rtl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_type,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] interp_y,
	input wire logic [1:0]  status
);

	// pending result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(interp_y) && $stable(status))
		else $error("result changed while stalled");

	// an append completes in the accept cycle
	a_append_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == pli_pkg::REQ_APPEND) |=> req_ready)
		else $error("append did not return to idle");

	// a query keeps the request side busy while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == pli_pkg::REQ_QUERY) |=> !req_ready)
		else $error("query accepted but block not busy");

	// a fresh result only appears out of a running query
	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared while idle");

	// flagged results carry zero
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != pli_pkg::STATUS_OK) |-> (interp_y == '0))
		else $error("nonzero y with error status");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.interp_y  (rsp.interp_y),
	.status    (rsp.status)
);

`default_nettype wire
